### rtl/core/rtd_pkg.sv
// shared types, constants and the reference resistance rom for the rtd converter
// no dependencies
`default_nettype none

package rtd_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 106;
  localparam int ROM_SIZE      = 106;
  localparam int STEP_DEGREES  = 10;
  localparam int START_TENTHS  = -2000;

  // entries actually searched
  localparam int N_USED = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                          ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);

  // tenths of a degree per table segment
  localparam int SCALE = STEP_DEGREES * 10;

  // field widths
  localparam int RES_W  = 16;
  localparam int TEMP_W = 15;
  localparam int STAT_W = 2;

  // search index covers 0..N_USED, rom address covers the stored table
  localparam int IDX_W   = $clog2(N_USED + 1);
  localparam int ROM_AW  = $clog2(ROM_SIZE);

  // quotient bits of the interpolation divide (fraction < SCALE)
  localparam int QW      = $clog2(SCALE);
  localparam int NUM_W   = RES_W + $clog2(SCALE + 1);
  localparam int DIV_W   = RES_W + QW + 1;

  // sequencer step counter
  localparam int MAX_STEPS = (IDX_W > QW) ? IDX_W : QW;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  // internal width of the temperature sum before wrapping
  localparam int SUM_W = 32;

  // saturation temperature at the last entry in use
  localparam int TOP_TENTHS = START_TENTHS + (N_USED - 1) * SCALE;

  // range status codes
  typedef enum logic [STAT_W-1:0] {
    RANGE_OK    = 2'd0,
    RANGE_BELOW = 2'd1,
    RANGE_ABOVE = 2'd2
  } range_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_DIV,
    ST_FIN
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              search;
    logic              mult;
    logic              divide;
    logic              publish;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;
  } sts_t;

  // reference resistances in 0.01 ohm, one every STEP_DEGREES from -200 C
  function automatic logic [RES_W-1:0] rom_at(input logic [ROM_AW-1:0] idx);
    logic [RES_W-1:0] v;
    case (idx)
      7'd0:   v = 16'd1849;
      7'd1:   v = 16'd2280;
      7'd2:   v = 16'd2708;
      7'd3:   v = 16'd3132;
      7'd4:   v = 16'd3553;
      7'd5:   v = 16'd3971;
      7'd6:   v = 16'd4387;
      7'd7:   v = 16'd4800;
      7'd8:   v = 16'd5211;
      7'd9:   v = 16'd5619;
      7'd10:  v = 16'd6025;
      7'd11:  v = 16'd6430;
      7'd12:  v = 16'd6833;
      7'd13:  v = 16'd7233;
      7'd14:  v = 16'd7633;
      7'd15:  v = 16'd8031;
      7'd16:  v = 16'd8427;
      7'd17:  v = 16'd8822;
      7'd18:  v = 16'd9216;
      7'd19:  v = 16'd9609;
      7'd20:  v = 16'd10000;
      7'd21:  v = 16'd10390;
      7'd22:  v = 16'd10779;
      7'd23:  v = 16'd11167;
      7'd24:  v = 16'd11554;
      7'd25:  v = 16'd11940;
      7'd26:  v = 16'd12324;
      7'd27:  v = 16'd12707;
      7'd28:  v = 16'd13089;
      7'd29:  v = 16'd13470;
      7'd30:  v = 16'd13850;
      7'd31:  v = 16'd14229;
      7'd32:  v = 16'd14606;
      7'd33:  v = 16'd14982;
      7'd34:  v = 16'd15358;
      7'd35:  v = 16'd15731;
      7'd36:  v = 16'd16104;
      7'd37:  v = 16'd16476;
      7'd38:  v = 16'd16846;
      7'd39:  v = 16'd17216;
      7'd40:  v = 16'd17584;
      7'd41:  v = 16'd17951;
      7'd42:  v = 16'd18317;
      7'd43:  v = 16'd18682;
      7'd44:  v = 16'd19045;
      7'd45:  v = 16'd19407;
      7'd46:  v = 16'd19769;
      7'd47:  v = 16'd20129;
      7'd48:  v = 16'd20488;
      7'd49:  v = 16'd20845;
      7'd50:  v = 16'd21202;
      7'd51:  v = 16'd21560;
      7'd52:  v = 16'd21915;
      7'd53:  v = 16'd22268;
      7'd54:  v = 16'd22620;
      7'd55:  v = 16'd22971;
      7'd56:  v = 16'd23321;
      7'd57:  v = 16'd23670;
      7'd58:  v = 16'd24017;
      7'd59:  v = 16'd24364;
      7'd60:  v = 16'd24709;
      7'd61:  v = 16'd25053;
      7'd62:  v = 16'd25396;
      7'd63:  v = 16'd25737;
      7'd64:  v = 16'd26078;
      7'd65:  v = 16'd26417;
      7'd66:  v = 16'd26756;
      7'd67:  v = 16'd27093;
      7'd68:  v = 16'd27429;
      7'd69:  v = 16'd27764;
      7'd70:  v = 16'd28097;
      7'd71:  v = 16'd28430;
      7'd72:  v = 16'd28761;
      7'd73:  v = 16'd29091;
      7'd74:  v = 16'd29420;
      7'd75:  v = 16'd29748;
      7'd76:  v = 16'd30075;
      7'd77:  v = 16'd30401;
      7'd78:  v = 16'd30725;
      7'd79:  v = 16'd31048;
      7'd80:  v = 16'd31370;
      7'd81:  v = 16'd31691;
      7'd82:  v = 16'd32011;
      7'd83:  v = 16'd32330;
      7'd84:  v = 16'd32647;
      7'd85:  v = 16'd32964;
      7'd86:  v = 16'd33279;
      7'd87:  v = 16'd33593;
      7'd88:  v = 16'd33906;
      7'd89:  v = 16'd34217;
      7'd90:  v = 16'd34528;
      7'd91:  v = 16'd34837;
      7'd92:  v = 16'd35146;
      7'd93:  v = 16'd35453;
      7'd94:  v = 16'd35759;
      7'd95:  v = 16'd36063;
      7'd96:  v = 16'd36367;
      7'd97:  v = 16'd36669;
      7'd98:  v = 16'd36971;
      7'd99:  v = 16'd37271;
      7'd100: v = 16'd37570;
      7'd101: v = 16'd37868;
      7'd102: v = 16'd38165;
      7'd103: v = 16'd38460;
      7'd104: v = 16'd38754;
      7'd105: v = 16'd39048;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rtd_req_if.sv
// request channel carrying one resistance reading
// depends on rtd_pkg
`default_nettype none

interface rtd_req_if;
  import rtd_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] resistance_centiohm;

  modport source (output valid, output resistance_centiohm, input ready);
  modport sink   (input valid, input resistance_centiohm, output ready);
endinterface

`default_nettype wire

### rtl/core/rtd_rsp_if.sv
// response channel carrying one temperature and its range status
// depends on rtd_pkg
`default_nettype none

interface rtd_rsp_if;
  import rtd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic [STAT_W-1:0]        range_status;

  modport source (output valid, output temperature_tenths, output range_status, input ready);
  modport sink   (input valid, input temperature_tenths, input range_status, output ready);
endinterface

`default_nettype wire

### rtl/core/rtd_ctrl.sv
// sequencer for the rtd converter: search, multiply, divide, publish
// depends on rtd_pkg
`default_nettype none

module rtd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rtd_pkg::sts_t sts_i,
  output rtd_pkg::cmd_t      cmd_o
);
  import rtd_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.step    = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_q == STEP_W'(IDX_W - 1)) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        step_d = '0;
        if (sts_i.in_range) begin
          cmd_o.mult = 1'b1;
          state_d    = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.divide = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_q == STEP_W'(QW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/rtd_dp.sv
// datapath for the rtd converter: rom search, interpolation multiply and divide
// depends on rtd_pkg
`default_nettype none

module rtd_dp (
  input  wire logic                     clk_i,
  input  wire rtd_pkg::cmd_t            cmd_i,
  output rtd_pkg::sts_t                 sts_o,
  input  wire logic [rtd_pkg::RES_W-1:0] resistance_i,
  output logic signed [rtd_pkg::TEMP_W-1:0] temperature_o,
  output logic [rtd_pkg::STAT_W-1:0]    status_o
);
  import rtd_pkg::*;

  logic [RES_W-1:0]         r_q;
  logic [IDX_W-1:0]         pos_q;
  logic [DIV_W-1:0]         rem_q;
  logic [RES_W-1:0]         span_q;
  logic [QW-1:0]            quo_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [STAT_W-1:0]        stat_q;

  logic [STEP_W-1:0]        sh;
  logic [IDX_W-1:0]         cand;
  logic                     take;
  logic [RES_W-1:0]         hi_val, lo_val, diff;
  logic [NUM_W-1:0]         prod;
  logic [DIV_W-1:0]         dvs;
  logic                     ge;
  logic [IDX_W-1:0]         seg;
  logic signed [SUM_W-1:0]  interp;
  logic signed [TEMP_W-1:0] temp_d;
  range_e                   stat_d;

  // binary search: try setting one index bit per step, msb first
  always_comb begin
    sh   = STEP_W'(IDX_W - 1) - cmd_i.step;
    cand = pos_q | (IDX_W'(1) << sh);
    take = (cand <= IDX_W'(N_USED)) &&
           (rom_at(ROM_AW'(cand - 1'b1)) <= r_q);
  end

  // segment endpoints and the scaled offset into the segment
  always_comb begin
    hi_val = rom_at(ROM_AW'(pos_q));
    lo_val = rom_at(ROM_AW'(pos_q - 1'b1));
    diff   = r_q - lo_val;
    prod   = NUM_W'(diff) * NUM_W'(SCALE);
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    dvs = DIV_W'(span_q) << (STEP_W'(QW - 1) - cmd_i.step);
    ge  = (rem_q >= dvs);
  end

  assign sts_o.in_range = (pos_q != '0) && (pos_q < IDX_W'(N_USED));

  // final temperature, saturated outside the table
  always_comb begin
    seg    = pos_q - 1'b1;
    interp = SUM_W'(START_TENTHS) + SUM_W'(seg) * SUM_W'(SCALE) + SUM_W'(quo_q);
    if (pos_q == '0) begin
      temp_d = TEMP_W'(START_TENTHS);
      stat_d = RANGE_BELOW;
    end else if (pos_q >= IDX_W'(N_USED)) begin
      temp_d = TEMP_W'(TOP_TENTHS);
      stat_d = RANGE_ABOVE;
    end else begin
      temp_d = interp[TEMP_W-1:0];
      stat_d = RANGE_OK;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= resistance_i;
      pos_q <= '0;
    end
    if (cmd_i.search && take) begin
      pos_q <= cand;
    end
    if (cmd_i.mult) begin
      rem_q  <= DIV_W'(prod);
      span_q <= hi_val - lo_val;
      quo_q  <= '0;
    end
    if (cmd_i.divide) begin
      if (ge) begin
        rem_q <= rem_q - dvs;
      end
      quo_q <= {quo_q[QW-2:0], ge};
    end
    if (cmd_i.publish) begin
      temp_q <= temp_d;
      stat_q <= stat_d;
    end
  end

  assign temperature_o = temp_q;
  assign status_o      = stat_q;

endmodule

`default_nettype wire

### rtl/core/rtd_resistance_to_temperature_top.sv
// pt100 resistance to temperature converter, top level
// depends on rtd_pkg, rtd_req_if, rtd_rsp_if, rtd_ctrl and rtd_dp
`default_nettype none

// Converts one PT100 reading in 0.01 ohm to a temperature in 0.1 C by
// linear interpolation in a 106-entry reference table spaced 10 C apart
// from -200 C. Readings below the first entry give -2000 with status 1,
// readings at or above the last entry give 8500 with status 2, otherwise
// status is 0. Items are handled one at a time: an in-range reading passes
// through the accepting state, 7 binary-search steps over the table, a
// multiply state, 7 steps of the restoring divider and a publish state
// before its result is registered; a saturated reading goes from the
// search through the multiply state straight to publish, skipping the
// multiply and divide. A result sits in an output register, so the next
// request is taken while it waits; a second result stalls in the publish
// state until it drains.

module rtd_resistance_to_temperature_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rtd_req_if.sink     req_i,
  rtd_rsp_if.source   rsp_o
);
  import rtd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and result register
  rtd_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .resistance_i  (req_i.resistance_centiohm),
    .temperature_o (rsp_o.temperature_tenths),
    .status_o      (rsp_o.range_status)
  );

endmodule

`default_nettype wire
